// ----- design/assert_macros.svh -----
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, held off while reset is low.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/dq_pkg.sv -----
// Types and constants of the array deque.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int VALUE_W   = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 4;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_empty;
  } deq_out_t;

endpackage

`default_nettype wire

// ----- design/dq_slot_ram.sv -----
// Slot store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module dq_slot_ram #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              we,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] wdata,
  input  wire logic                              re,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr_b,
  output logic signed [dq_pkg::VALUE_W-1:0]      rdata_a,
  output logic signed [dq_pkg::VALUE_W-1:0]      rdata_b
);
  import dq_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

`include "assert_macros.svh"

  // the controller never writes and reads in the same cycle, so no forwarding
  `DQ_ASSERT(a_no_rw_overlap, !(we && re), "slot write and read in the same cycle")

endmodule

`default_nettype wire

// ----- design/dq_ctrl.sv -----
// Deque controller: index state, request decode, slot access sequencing.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dq_pkg::deq_in_t                   in_data,
  output logic                                   we,
  output logic [$clog2(DEPTH)-1:0]               waddr,
  output logic signed [dq_pkg::VALUE_W-1:0]      wdata,
  output logic                                   re,
  output logic [$clog2(DEPTH)-1:0]               raddr_a,
  output logic [$clog2(DEPTH)-1:0]               raddr_b,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] rdata_a,
  input  wire logic signed [dq_pkg::VALUE_W-1:0] rdata_b,
  input  wire logic                              res_free,
  output logic                                   res_load,
  output dq_pkg::deq_out_t                       res_data
);
  import dq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          empty_r, empty_nxt;
  status_t       status_r, status_nxt;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      empty_r  <= 1'b1;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      empty_r  <= empty_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = in_data.push_value;
    res_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt  = S_READ;
          status_nxt = ST_DONE;
          unique case (in_data.operation) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (empty_r) begin
                // first item always lands in slot zero
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b0;
                we        = 1'b1;
                waddr     = '0;
              end else if (in_data.operation == OP_PUSH_BACK) begin
                if (tail_r == LAST_IDX) begin
                  status_nxt = ST_OVERFLOW;
                end else begin
                  tail_nxt = tail_r + 1'b1;
                  we       = 1'b1;
                  waddr    = tail_r + 1'b1;
                end
              end else begin
                if (head_r == '0) begin
                  status_nxt = ST_OVERFLOW;
                end else begin
                  head_nxt = head_r - 1'b1;
                  we       = 1'b1;
                  waddr    = head_r - 1'b1;
                end
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (empty_r) begin
                status_nxt = ST_UNDERFLOW;
              end else if (head_r == tail_r) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b1;
              end else if (in_data.operation == OP_POP_BACK) begin
                tail_nxt = tail_r - 1'b1;
              end else begin
                head_nxt = head_r + 1'b1;
              end
            end
            default: begin
              // query and unused codes leave the indices and empty flag alone
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign re       = (state_r == S_READ);
  assign raddr_a  = head_r;
  assign raddr_b  = tail_r;

  assign count = CW'(tail_r) - CW'(head_r) + CW'(1);

  always_comb begin
    res_data.status = status_r;
    if (empty_r) begin
      res_data.front_value = EMPTY_VALUE;
      res_data.back_value  = EMPTY_VALUE;
      res_data.item_count  = '0;
      res_data.is_empty    = 1'b1;
    end else begin
      res_data.front_value = rdata_a;
      res_data.back_value  = rdata_b;
      res_data.item_count  = count[COUNT_W-1:0];
      res_data.is_empty    = 1'b0;
    end
  end

`include "assert_macros.svh"

  `DQ_ASSERT_ALWAYS(a_idx_order, !empty_r |-> head_r <= tail_r, "head index past tail index")
  `DQ_ASSERT_ALWAYS(a_empty_idx, empty_r |-> (head_r == '0 && tail_r == '0),
                    "empty deque with nonzero index")
  `DQ_ASSERT(a_read_then_result, (state_r == S_READ) |=> (state_r == S_RESULT && !in_ready),
             "read data not followed by result stage")

endmodule

`default_nettype wire

// ----- design/dq_out_stage.sv -----
// Result output register with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

module dq_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire dq_pkg::deq_out_t  res_data,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dq_pkg::deq_out_t       out_data
);
  import dq_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  deq_out_t out_data_r;

  // a held item that is taken this cycle frees the register for the next
  assign free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `DQ_ASSERT(a_load_when_free, load |-> free, "result loaded over an item not yet taken")

endmodule

`default_nettype wire

// ----- design/array_double_ended_queue.sv -----
// Array deque: non-circular store of DEPTH signed 32-bit items.
//
// Input channel in_valid/in_ready/in_data carries one request: an operation
// (push back, push front, pop back, pop front, query) and a push value.
// Result channel out_valid/out_ready/out_data returns one item per request:
// status, front and back values (-1 when empty), item count, empty flag, all
// as they stand after the request.
// A request is accepted in S_IDLE, where it updates the indices and writes
// its slot; the slot RAM is read at the new head and tail in S_READ, and
// its registered data forms the result in S_RESULT, which loads it into
// the output register once that register is free.
// A new request is accepted only once the previous one has finished that
// write/read/result sequence on the single slot RAM.
// When the receiver stalls, the result waits in the output register; one
// more request can be accepted and processed, then the block holds until
// the output register frees up.
// Reset (rst_n low, synchronous): deque empty, indices zero, no result
// pending. Slot contents are left as they are; only written slots are read.
`timescale 1ns / 1ps
`default_nettype none

module array_double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire dq_pkg::deq_in_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dq_pkg::deq_out_t      out_data
);
  import dq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic                      we;
  logic [IW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic                      re;
  logic [IW-1:0]             raddr_a;
  logic [IW-1:0]             raddr_b;
  logic signed [VALUE_W-1:0] rdata_a;
  logic signed [VALUE_W-1:0] rdata_b;
  logic                      res_free;
  logic                      res_load;
  deq_out_t                  res_data;

  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .res_free (res_free),
    .res_load (res_load),
    .res_data (res_data)
  );

  dq_slot_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  dq_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res_data  (res_data),
    .free      (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
